// ===== rtl/bda_pkg.sv =====
// Shared widths, types and constants of the boxcar decimating averager.
// No dependencies; every other file of the block but bda_queue imports it.
package bda_pkg;

	localparam int SAMPLE_W = 16;
	localparam int MEAN_W   = 16;
	localparam int CFG_W    = 9;

	localparam logic [CFG_W-1:0] FACTOR_RESET = CFG_W'(1);
	localparam logic [CFG_W-1:0] FACTOR_UNITY = CFG_W'(1);

	typedef struct packed {
		logic idle;
		logic done;
	} back_stat_t;

endpackage

// ===== rtl/bda_if.sv =====
// Valid/ready stream interfaces for the sample input and the mean output.
// Depends on bda_pkg for field widths.
interface bda_sample_if;
	import bda_pkg::*;
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] sample_in;
	modport source (output valid, output sample_in, input ready);
	modport sink   (input valid, input sample_in, output ready);
endinterface

interface bda_mean_if;
	import bda_pkg::*;
	logic              valid;
	logic              ready;
	logic [MEAN_W-1:0] mean_out;
	modport source (output valid, output mean_out, input ready);
	modport sink   (input valid, input mean_out, output ready);
endinterface

// ===== rtl/bda_queue.sv =====
// Short FIFO between the accumulating front end and the dividing back end.
// Depends on nothing but its parameters.
module bda_queue #(
	parameter int W     = 33,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wr_data,
	input  logic         pop,
	output logic [W-1:0] rd_data,
	output logic         full,
	output logic         empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign rd_data = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= nxt(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= nxt(rd_ptr_q);
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + CW'(1);
				2'b01:   cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule

// ===== rtl/bda_front.sv =====
// Front end: holds the factor register, accepts samples and accumulates groups.
// Pushes each completed group sum with its factor into the queue; uses bda_pkg.
module bda_front #(
	parameter int MAX_FACTOR = 256,
	parameter int SUM_W      = 24
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [bda_pkg::CFG_W-1:0]   cfg_wdata,
	bda_sample_if.sink                  samples,
	input  logic                        q_full,
	output logic                        q_push,
	output logic [bda_pkg::CFG_W-1:0]   q_factor,
	output logic [SUM_W-1:0]            q_sum
);
	import bda_pkg::*;

	localparam int CNT_W = (MAX_FACTOR > 2) ? $clog2(MAX_FACTOR) : 1;
	localparam int CMP_W = ((CNT_W > CFG_W) ? CNT_W : CFG_W) + 1;
	localparam int SAT   = (MAX_FACTOR < 511) ? MAX_FACTOR : 511;

	logic [CFG_W-1:0] factor_q;
	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CFG_W-1:0] eff_factor;
	logic [SUM_W-1:0] sum_next;
	logic             accept;
	logic             last;

	always_comb begin
		eff_factor = factor_q;
		if (eff_factor == '0) begin
			eff_factor = FACTOR_UNITY;
		end else if (eff_factor > CFG_W'(SAT)) begin
			eff_factor = CFG_W'(SAT);
		end
	end

	assign samples.ready = !q_full;
	assign accept        = samples.valid && samples.ready;
	assign sum_next      = sum_q + SUM_W'(samples.sample_in);
	assign last          = (CMP_W'(cnt_q) + CMP_W'(1)) >= CMP_W'(eff_factor);

	assign q_push   = accept && last;
	assign q_factor = eff_factor;
	assign q_sum    = sum_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			factor_q <= FACTOR_RESET;
			sum_q    <= '0;
			cnt_q    <= '0;
		end else if (cfg_we) begin
			factor_q <= cfg_wdata;
			sum_q    <= '0;
			cnt_q    <= '0;
		end else if (accept) begin
			if (last) begin
				sum_q <= '0;
				cnt_q <= '0;
			end else begin
				sum_q <= sum_next;
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end
endmodule

// ===== rtl/bda_back.sv =====
// Back end: pops group sums, divides by the factor one quotient bit a cycle,
// rounds, and holds the mean in the output register; uses bda_pkg.
module bda_back #(
	parameter int SUM_W = 24
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_empty,
	input  logic [bda_pkg::CFG_W-1:0]   q_factor,
	input  logic [SUM_W-1:0]            q_sum,
	output logic                        q_pop,
	bda_mean_if.source                  means,
	output bda_pkg::back_stat_t         stat
);
	import bda_pkg::*;

	localparam int BW = $clog2(SUM_W);

	typedef enum logic [1:0] {
		IDLE,
		DIV,
		DONE
	} state_t;

	state_t           state_q;
	logic [SUM_W-1:0] dvd_q;
	logic [SUM_W-1:0] quo_q;
	logic [CFG_W-1:0] rem_q;
	logic [CFG_W-1:0] fac_q;
	logic [BW-1:0]    bit_q;
	logic             out_valid_q;
	logic [MEAN_W-1:0] mean_q;

	logic [CFG_W:0]    rem_sh;
	logic              q_bit;
	logic [CFG_W:0]    rem_sub;
	logic              round_up;
	logic [MEAN_W-1:0] mean_next;
	logic              slot_free;
	logic              load_mean;

	assign rem_sh    = {rem_q, dvd_q[SUM_W-1]};
	assign q_bit     = rem_sh >= {1'b0, fac_q};
	assign rem_sub   = rem_sh - {1'b0, fac_q};
	assign round_up  = rem_q > (fac_q >> 1);
	assign mean_next = quo_q[MEAN_W-1:0] + MEAN_W'(round_up);
	assign slot_free = !out_valid_q || means.ready;
	assign load_mean = (state_q == DONE) && slot_free;

	assign q_pop          = (state_q == IDLE) && !q_empty;
	assign means.valid    = out_valid_q;
	assign means.mean_out = mean_q;
	assign stat.idle      = (state_q == IDLE);
	assign stat.done      = (state_q == DONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			out_valid_q <= 1'b0;
			dvd_q       <= '0;
			quo_q       <= '0;
			rem_q       <= '0;
			fac_q       <= FACTOR_UNITY;
			bit_q       <= '0;
			mean_q      <= '0;
		end else begin
			if (load_mean) begin
				out_valid_q <= 1'b1;
			end else if (means.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (!q_empty) begin
						fac_q <= q_factor;
						rem_q <= '0;
						if (q_factor == FACTOR_UNITY) begin
							quo_q   <= q_sum;
							state_q <= DONE;
						end else begin
							dvd_q   <= q_sum;
							bit_q   <= BW'(SUM_W - 1);
							state_q <= DIV;
						end
					end
				end
				DIV: begin
					rem_q <= q_bit ? rem_sub[CFG_W-1:0] : rem_sh[CFG_W-1:0];
					quo_q <= {quo_q[SUM_W-2:0], q_bit};
					dvd_q <= {dvd_q[SUM_W-2:0], 1'b0};
					bit_q <= bit_q - BW'(1);
					if (bit_q == '0) begin
						state_q <= DONE;
					end
				end
				DONE: begin
					if (load_mean) begin
						mean_q  <= mean_next;
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/boxcar_decimating_averager_core.sv =====
// Top level of the boxcar decimating averager: front end, queue, back end.
// Depends on bda_pkg, bda_if, bda_front, bda_queue and bda_back.
//
// Usage: samples arrive as beats on the samples channel (16-bit unsigned,
// valid/ready). Every decimation_factor beats form one group; at the end of
// a group one rounded mean leaves as a beat on the means channel. The factor
// is written through cfg_we/cfg_wdata while the block is idle; a write
// discards any partial group. Factor 0 acts as 1, values above MAX_FACTOR
// saturate.
// Throughput: the front end takes one sample beat per cycle as long as the
// queue has room. The back end divides with a radix-2 restoring divider,
// one quotient bit per cycle, and pops the next group only once the mean
// of the last is loaded; a factor of 1 skips the divider. Reset clears the
// partial group, empties the queue and the output register and sets the
// factor to 1. When the receiver stalls the mean holds in the output
// register, the back end then stalls, the queue fills and the samples
// channel drops ready.
module boxcar_decimating_averager_core #(
	parameter int MAX_FACTOR = 256
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [bda_pkg::CFG_W-1:0] cfg_wdata,
	bda_sample_if.sink                samples,
	bda_mean_if.source                means
);
	import bda_pkg::*;

	localparam int SUM_W   = SAMPLE_W + ((MAX_FACTOR > 2) ? $clog2(MAX_FACTOR) : 1);
	localparam int Q_DEPTH = 4;
	localparam int QW      = CFG_W + SUM_W;

	logic             q_push;
	logic             q_pop;
	logic             q_full;
	logic             q_empty;
	logic [CFG_W-1:0] wr_factor;
	logic [SUM_W-1:0] wr_sum;
	logic [QW-1:0]    rd_data;
	back_stat_t       stat;

	bda_front #(
		.MAX_FACTOR (MAX_FACTOR),
		.SUM_W      (SUM_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.samples   (samples),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_factor  (wr_factor),
		.q_sum     (wr_sum)
	);

	bda_queue #(
		.W     (QW),
		.DEPTH (Q_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_data ({wr_factor, wr_sum}),
		.pop     (q_pop),
		.rd_data (rd_data),
		.full    (q_full),
		.empty   (q_empty)
	);

	bda_back #(
		.SUM_W (SUM_W)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_factor (rd_data[QW-1:SUM_W]),
		.q_sum    (rd_data[SUM_W-1:0]),
		.q_pop    (q_pop),
		.means    (means),
		.stat     (stat)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("group pushed into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty && stat.idle)
		else $error("queue popped while empty or back end busy");

	a_mean_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(means.valid) |-> $past(stat.done))
		else $error("mean became valid without a finished division");
endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for boxcar_decimating_averager_core: a directed table, then random
// factor phases, checked beat by beat against a cycle-free averaging predictor.
// Depends on bda_pkg, bda_if and the core RTL.
module tb;
	import bda_pkg::*;

	localparam int MAX_FACTOR  = 256;
	localparam int RAND_ITEMS  = 1500;
	localparam int DRAIN_WAIT  = 40;
	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 3000;
	localparam int N_STEPS     = 29;

	typedef struct {
		bit                  is_cfg;
		logic [SAMPLE_W-1:0] value;
		bit                  typed;
		logic [MEAN_W-1:0]   mean;
	} step_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CFG_W-1:0] cfg_wdata;

	bda_sample_if smp ();
	bda_mean_if   mns ();

	boxcar_decimating_averager_core #(.MAX_FACTOR(MAX_FACTOR)) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.samples  (smp),
		.means    (mns)
	);

	logic [CFG_W-1:0]  factor_reg;
	logic [23:0]       acc_sum;
	logic [7:0]        acc_count;
	logic [MEAN_W-1:0] means_due [$];
	int                fails;
	int                means_seen;
	int                samples_sent;
	int                settings_done;
	int                quiet_cycles;
	bit                idle_on;
	bit                hold_req;
	step_t             dir_steps [N_STEPS];

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic bit average_sample(input logic [SAMPLE_W-1:0] s,
			output logic [MEAN_W-1:0] mean);
		int unsigned f;
		int unsigned q;
		int unsigned r;
		f = 32'(factor_reg);
		if (f == 0)
			f = 1;
		if (f > MAX_FACTOR)
			f = MAX_FACTOR;
		acc_sum = acc_sum + 24'(s);
		mean = '0;
		if (32'(acc_count) + 1 < f) begin
			acc_count = acc_count + 8'd1;
			return 1'b0;
		end
		q = 32'(acc_sum) / f;
		r = 32'(acc_sum) % f;
		mean = MEAN_W'(q + ((r > (f >> 1)) ? 1 : 0));
		acc_sum = '0;
		acc_count = '0;
		return 1'b1;
	endfunction

	function automatic logic [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(9))
			0: return '1;
			1: return '0;
			2: return SAMPLE_W'($urandom_range(3));
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] pick_factor();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 50)
			return CFG_W'($urandom_range(4, 1));
		if (r < 75)
			return CFG_W'($urandom_range(16, 5));
		if (r < 88)
			return CFG_W'($urandom_range(64, 17));
		if (r < 94)
			return '0;
		if (r < 97)
			return CFG_W'(MAX_FACTOR);
		return CFG_W'($urandom_range(511, MAX_FACTOR + 1));
	endfunction

	task automatic send_sample(input logic [SAMPLE_W-1:0] v, input bit typed,
			input logic [MEAN_W-1:0] typed_mean);
		logic [MEAN_W-1:0] m;
		@(negedge clk);
		while (idle_on && $urandom_range(99) < 36) begin
			smp.valid = 1'b0;
			@(negedge clk);
		end
		smp.valid     = 1'b1;
		smp.sample_in = v;
		do @(posedge clk); while (!smp.ready);
		samples_sent++;
		if (average_sample(v, m))
			means_due.push_back(typed ? typed_mean : m);
	endtask

	task automatic drain_means();
		@(negedge clk);
		smp.valid = 1'b0;
		while (means_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_factor(input logic [CFG_W-1:0] f);
		drain_means();
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_wdata = f;
		@(negedge clk);
		cfg_we     = 1'b0;
		factor_reg = f;
		acc_sum    = '0;
		acc_count  = '0;
		settings_done++;
	endtask

	initial begin
		mns.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				mns.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			mns.ready = !(idle_on && $urandom_range(99) < 36);
		end
	end

	always @(posedge clk) begin
		logic [MEAN_W-1:0] exp_mean;
		if (arst_n) begin
			if ((smp.valid && smp.ready) || (mns.valid && mns.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (mns.valid && mns.ready) begin
				means_seen++;
				if (means_due.size() == 0) begin
					$error("mean_out: no mean expected, actual %0d", mns.mean_out);
					fails++;
				end else begin
					exp_mean = means_due.pop_front();
					if (mns.mean_out !== exp_mean) begin
						$error("mean_out expected %0d actual %0d", exp_mean, mns.mean_out);
						fails++;
					end
				end
			end
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		int unsigned      phase;
		int unsigned      eff;
		int unsigned      n_items;
		logic [CFG_W-1:0] f;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = '0;
		smp.valid     = 1'b0;
		smp.sample_in = '0;
		idle_on       = 1'b1;
		hold_req      = 1'b0;
		factor_reg    = FACTOR_RESET;
		acc_sum       = '0;
		acc_count     = '0;
		dir_steps = '{
			'{1'b0, 16'd0,     1'b1, 16'd0},
			'{1'b0, 16'hFFFF,  1'b1, 16'hFFFF},
			'{1'b0, 16'h5A5A,  1'b1, 16'h5A5A},
			'{1'b0, 16'hA5A5,  1'b1, 16'hA5A5},
			'{1'b1, 16'd0,     1'b0, 16'd0},
			'{1'b0, 16'd1234,  1'b1, 16'd1234},
			'{1'b1, 16'd2,     1'b0, 16'd0},
			'{1'b0, 16'hFFFF,  1'b0, 16'd0},
			'{1'b0, 16'hFFFF,  1'b1, 16'hFFFF},
			'{1'b0, 16'd0,     1'b0, 16'd0},
			'{1'b0, 16'd1,     1'b1, 16'd0},
			'{1'b1, 16'd3,     1'b0, 16'd0},
			'{1'b0, 16'd0,     1'b0, 16'd0},
			'{1'b0, 16'd0,     1'b0, 16'd0},
			'{1'b0, 16'd2,     1'b1, 16'd1},
			'{1'b1, 16'd4,     1'b0, 16'd0},
			'{1'b0, 16'd5,     1'b0, 16'd0},
			'{1'b0, 16'd5,     1'b0, 16'd0},
			'{1'b1, 16'd4,     1'b0, 16'd0},
			'{1'b0, 16'd1,     1'b0, 16'd0},
			'{1'b0, 16'd1,     1'b0, 16'd0},
			'{1'b0, 16'd1,     1'b0, 16'd0},
			'{1'b0, 16'd3,     1'b1, 16'd1},
			'{1'b1, 16'd5,     1'b0, 16'd0},
			'{1'b0, 16'd9,     1'b0, 16'd0},
			'{1'b0, 16'd0,     1'b0, 16'd0},
			'{1'b0, 16'd0,     1'b0, 16'd0},
			'{1'b0, 16'd0,     1'b0, 16'd0},
			'{1'b0, 16'd0,     1'b0, 16'd0}
		};
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		foreach (dir_steps[i]) begin
			if (dir_steps[i].is_cfg)
				write_factor(CFG_W'(dir_steps[i].value));
			else
				send_sample(dir_steps[i].value, dir_steps[i].typed, dir_steps[i].mean);
		end

		phase = 0;
		while (samples_sent < RAND_ITEMS || means_seen < 48 || phase < 8) begin
			idle_on = !(phase >= 4 && phase < 8);
			case (phase)
				0: f = '1;
				1: f = CFG_W'(MAX_FACTOR);
				2: f = FACTOR_UNITY;
				default: f = pick_factor();
			endcase
			write_factor(f);
			eff = (f == 0) ? 1 : (f > MAX_FACTOR) ? MAX_FACTOR : 32'(f);
			if (eff == MAX_FACTOR)
				n_items = eff * $urandom_range(2, 1);
			else
				n_items = eff * $urandom_range(8, 1);
			if ($urandom_range(2) == 0)
				n_items += $urandom_range(eff - 1);
			if (phase == 2) begin
				hold_req = 1'b1;
				n_items  = 80;
			end
			for (int unsigned k = 0; k < n_items; k++)
				send_sample((phase == 0) ? '1 : pick_sample(), 1'b0, '0);
			phase++;
		end

		drain_means();
		$display("Averaged %0d samples into %0d checked means over %0d factor writes,",
			samples_sent, means_seen, settings_done);
		$display("covering zero and saturated factors, partial-group discard and output stall.");
		if (fails == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/bda_pkg.sv
rtl/bda_if.sv
rtl/bda_queue.sv
rtl/bda_front.sv
rtl/bda_back.sv
rtl/boxcar_decimating_averager_core.sv
dv/tb.sv
